[hdl/pwt_pkg.sv]
`default_nettype none
package pwt_pkg;
    typedef enum logic [2:0] {
        REASON_PASS    = 3'd0,
        REASON_SMALL   = 3'd1,
        REASON_POWER   = 3'd2,
        REASON_ROOT    = 3'd3,
        REASON_DIVISOR = 3'd4
    } t_reason;

    localparam logic [1:0] ACT_FERMAT = 2'd0;
    localparam logic [1:0] ACT_STRONG = 2'd1;
endpackage
`default_nettype wire

[hdl/pwt_if.sv]
`default_nettype none
interface pwt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] candidate;
    logic [31:0] witness;
    modport source (output valid, action, candidate, witness, input ready);
    modport sink   (input valid, action, candidate, witness, output ready);
endinterface

interface pwt_out_if;
    logic       valid;
    logic       ready;
    logic       probably_prime;
    logic [2:0] reason;
    modport source (output valid, probably_prime, reason, input ready);
    modport sink   (input valid, probably_prime, reason, output ready);
endinterface
`default_nettype wire

[hdl/primality_witness_tester_core.sv]
`default_nettype none
// Primality witness tester. One item on the input channel (action, candidate,
// witness) gives one beat on the output channel (probably_prime, reason).
// Only the low WIDTH bits of candidate and witness are used.
// Action 0 is a Fermat round, 1 a strong round, 2 or 3 trial division.
// All modular work goes through one serial remainder unit. An exponent round
// needs up to 2*WIDTH-1 reductions. Trial division runs one divisor per
// reduction up to sqrt(n)+1, after a bitwise square root of the candidate.
// Candidates below two, and trial division of two, go straight to the result.
// The block takes one item at a time: in_ready is high only when idle.
// The result is held in an output register until taken; a stalled receiver
// just holds the block off the next item. Reset (synchronous, active low)
// returns to idle with no result pending.
module primality_witness_tester_core #(
    parameter int WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pwt_in_if.sink    i_in,
    pwt_out_if.source o_out
);
    import pwt_pkg::*;

    localparam int W = WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SQRT, S_RED_A, S_WAIT, S_EXP, S_TRIAL, S_DONE
    } t_state;

    // what the pending reduction is for
    typedef enum logic [1:0] {OP_INIT, OP_SQ, OP_MUL, OP_TRIAL} t_op;

    t_state          r_state;
    t_op             r_op;
    logic            r_strong;
    logic            r_trial;
    logic [W-1:0]    r_n;
    logic [W-1:0]    r_a;
    logic [W-1:0]    r_e;
    logic [W-1:0]    r_z;
    logic [W-1:0]    r_y;
    logic [W-1:0]    r_d;
    logic [16:0]     r_lim;
    logic [16:0]     r_sq;
    logic [15:0]     r_bit;
    t_reason         r_reason;
    logic            r_ovalid;

    logic            red_start;
    logic [2*W-1:0]  red_dividend;
    logic [W-1:0]    red_divisor;
    logic            red_done;
    logic [W-1:0]    red_rem;
    logic [W-1:0]    n_mask_n;
    logic [W-1:0]    top;
    logic [16:0]     sq_try;
    logic [33:0]     sq_prod;

    pwt_modred #(.W(W)) u_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (red_start),
        .i_dividend (red_dividend),
        .i_divisor  (red_divisor),
        .o_done     (red_done),
        .o_rem      (red_rem)
    );

    assign top     = r_n - 1'b1;
    assign n_mask_n = i_in.candidate[W-1:0];
    assign sq_try  = {1'b0, r_sq[15:0] | r_bit};
    assign sq_prod = 34'(sq_try) * 34'(sq_try);

    // operands for the shared reducer
    always_comb begin
        red_start    = 1'b0;
        red_dividend = '0;
        red_divisor  = r_n;
        unique case (r_state)
            S_RED_A: begin
                red_start    = 1'b1;
                red_dividend = {{W{1'b0}}, r_a};
            end
            S_EXP: begin
                red_start = (r_e != '0);
                if (!r_e[0]) red_dividend = (2*W)'(r_z) * (2*W)'(r_z);
                else         red_dividend = (2*W)'(r_y) * (2*W)'(r_z);
            end
            S_TRIAL: begin
                red_start    = ({16'b0, r_lim} >= 33'(r_d));
                red_dividend = {{W{1'b0}}, r_n};
                red_divisor  = r_d;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in.valid) begin
                    r_n      <= n_mask_n;
                    r_a      <= i_in.witness[W-1:0];
                    r_strong <= (i_in.action == ACT_STRONG);
                    r_trial  <= i_in.action[1];
                    r_state  <= S_PREP;
                end
                S_PREP: begin
                    r_sq  <= '0;
                    r_bit <= 16'h8000;
                    r_e   <= top;
                    r_y   <= W'(1);
                    r_d   <= W'(2);
                    if (r_n < W'(2)) begin
                        r_reason <= REASON_SMALL;
                        r_state  <= S_DONE;
                    end else if (r_trial) begin
                        if (r_n == W'(2)) begin
                            r_reason <= REASON_PASS;
                            r_state  <= S_DONE;
                        end else r_state <= S_SQRT;
                    end else begin
                        r_state <= S_RED_A;
                    end
                end
                // bitwise integer square root, one bit a cycle
                S_SQRT: begin
                    if (sq_prod <= 34'(r_n)) r_sq <= sq_try;
                    r_bit <= r_bit >> 1;
                    if (r_bit == 16'd1) begin
                        r_lim   <= ((sq_prod <= 34'(r_n)) ? sq_try : r_sq) + 17'd1;
                        r_state <= S_TRIAL;
                    end
                end
                S_RED_A: begin
                    r_op    <= OP_INIT;
                    r_state <= S_WAIT;
                end
                S_EXP: begin
                    if (r_e == '0) begin
                        r_reason <= (r_y == W'(1)) ? REASON_PASS : REASON_POWER;
                        r_state  <= S_DONE;
                    end else begin
                        r_op    <= r_e[0] ? OP_MUL : OP_SQ;
                        r_state <= S_WAIT;
                    end
                end
                S_TRIAL: begin
                    if (red_start) begin
                        r_op    <= OP_TRIAL;
                        r_state <= S_WAIT;
                    end else begin
                        r_reason <= REASON_PASS;
                        r_state  <= S_DONE;
                    end
                end
                S_WAIT: if (red_done) begin
                    unique case (r_op)
                        OP_INIT: begin
                            r_z     <= red_rem;
                            r_state <= S_EXP;
                        end
                        OP_SQ: begin
                            r_z <= red_rem;
                            r_e <= r_e >> 1;
                            if (r_strong && red_rem == W'(1) && r_z != W'(1)
                                && r_z != top) begin
                                r_reason <= REASON_ROOT;
                                r_state  <= S_DONE;
                            end else r_state <= S_EXP;
                        end
                        OP_MUL: begin
                            r_y     <= red_rem;
                            r_e     <= r_e - 1'b1;
                            r_state <= S_EXP;
                        end
                        OP_TRIAL: begin
                            if (red_rem == '0) begin
                                r_reason <= REASON_DIVISOR;
                                r_state  <= S_DONE;
                            end else begin
                                r_d     <= r_d + 1'b1;
                                r_state <= S_TRIAL;
                            end
                        end
                        default: r_state <= S_EXP;
                    endcase
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end else if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.reason         = r_reason;
    assign o_out.probably_prime = (r_reason == REASON_PASS);

    // output only valid while finishing
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_state == S_DONE) else $error("valid outside done");
    // no new item while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("ready with result");
    // reducer finishes only when awaited
    a_red_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_done |-> r_state == S_WAIT) else $error("stray reducer done");
endmodule
`default_nettype wire

[hdl/pwt_modred.sv]
`default_nettype none
// Serial restoring remainder: a mod m, one quotient bit a cycle.
// Dividend is 2*W bits, the divisor W bits.
module pwt_modred #(
    parameter int W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [2*W-1:0]   i_dividend,
    input  wire logic [W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [W-1:0]          o_rem
);
    localparam int CW = $clog2(2*W+1);

    logic [2*W-1:0] r_num;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_div;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W+1:0]   n_shift;
    logic [W+1:0]   n_diff;

    // one shift and trial subtract per cycle
    always_comb begin
        n_shift = {r_rem, r_num[2*W-1]};
        n_diff  = n_shift - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(2*W);
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[2*W-2:0], 1'b0};
                if (!n_diff[W+1]) r_rem <= n_diff[W:0];
                else              r_rem <= n_shift[W:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[W-1:0];
endmodule
`default_nettype wire
